// ===== src/uart_baud_divisor_search_defines.svh =====
// Assertion macros for the checker file.
`ifndef UART_BAUD_DIVISOR_SEARCH_DEFINES_SVH
`define UART_BAUD_DIVISOR_SEARCH_DEFINES_SVH

// Check a property outside reset.
`define UBDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ubds: assertion failed");

// Check a property at every edge, reset included.
`define UBDS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ubds: assertion failed");

`endif

// ===== src/ubds_pkg.sv =====
`default_nettype none
package ubds_pkg;

  localparam int unsigned CLK_W  = 32;
  localparam int unsigned BAUD_W = 24;
  localparam int unsigned DIV_W  = 8;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned QCNT_W = 5;

  localparam logic [CLK_W-1:0]  SLOW_CLK_LIMIT = 32'd1000000;
  localparam logic [BAUD_W-1:0] SLOW_RATE_CAP  = 24'd4800;
  localparam logic [DIV_W-1:0]  DIV_FIRST      = 8'd4;
  localparam logic [DIV_W-1:0]  DIV_LAST       = 8'd254;
  localparam logic [DIV_W-1:0]  DIV_NONE       = 8'd255;
  localparam logic [GEN_W-1:0]  GEN_MIN        = 32'd2;
  localparam logic [GEN_W-1:0]  GEN_MAX        = 32'd65535;
  localparam logic [6:0]        ERR_SCALE      = 7'd100;
  localparam logic [GEN_W-1:0]  ERR_LIMIT      = 32'd3;

  typedef struct packed {
    logic             start;
    logic [GEN_W-1:0] num;
    logic [GEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [GEN_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/uart_baud_divisor_search.sv =====
// Each candidate divider, 4 to 254, takes one division on the shared serial divider if its
// generator is out of range, else three; the search ends at the first accepted divider or
// after all 251 fail.
// One transaction at a time; the next is taken once the result is registered, while that
// result may still wait at the output.
// Reset (rst_n, synchronous, active low) returns to idle and drops out_valid.
`default_nettype none
module uart_baud_divisor_search (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ubds_pkg::CLK_W-1:0]  in_clock_hz,
  input  wire logic [ubds_pkg::BAUD_W-1:0] in_baud_request,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ubds_pkg::DIV_W-1:0]       out_divider,
  output logic [ubds_pkg::GEN_W-1:0]       out_generator,
  output logic                              out_found
);

  typedef enum logic [3:0] {
    S_IDLE, S_GEN_MUL, S_GEN_DIV, S_ACH_MUL, S_ACH_DIV,
    S_ERR_MUL, S_ERR_DIV, S_NEXT, S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ubds_pkg::CLK_W-1:0]  clk_r, clk_nxt;
  logic [ubds_pkg::BAUD_W-1:0] rate_r, rate_nxt;
  logic [ubds_pkg::DIV_W-1:0]  div_r, div_nxt;
  logic [ubds_pkg::GEN_W-1:0]  gen_r, gen_nxt;
  logic [ubds_pkg::GEN_W-1:0]  err_r, err_nxt;
  logic                        hit_r, hit_nxt;
  logic                        start_r, start_nxt;
  logic [ubds_pkg::GEN_W-1:0]  num_r, num_nxt;
  logic [ubds_pkg::GEN_W-1:0]  den_r, den_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic [ubds_pkg::DIV_W-1:0]  odiv_r, odiv_nxt;
  logic [ubds_pkg::GEN_W-1:0]  ogen_r, ogen_nxt;
  logic                        ofound_r, ofound_nxt;

  logic [ubds_pkg::DIV_W:0]        divp1;
  logic [ubds_pkg::BAUD_W+ubds_pkg::DIV_W:0] rate_prod;
  logic [16+ubds_pkg::DIV_W:0]     gen_prod;
  logic [ubds_pkg::GEN_W+6:0]      err_prod;
  logic [ubds_pkg::GEN_W-1:0]      rate_ext;
  logic [ubds_pkg::GEN_W-1:0]      quo;
  ubds_pkg::div_req_t              dreq;
  ubds_pkg::div_rsp_t              drsp;

  assign divp1     = {1'b0, div_r} + 1'b1;
  assign rate_prod = {{(ubds_pkg::DIV_W+1){1'b0}}, rate_r}
                   * {{ubds_pkg::BAUD_W{1'b0}}, divp1};
  assign gen_prod  = {{(ubds_pkg::DIV_W+1){1'b0}}, gen_r[15:0]} * {16'd0, divp1};
  assign err_prod  = {7'd0, err_r} * {{ubds_pkg::GEN_W{1'b0}}, ubds_pkg::ERR_SCALE};
  assign rate_ext  = {{(ubds_pkg::GEN_W-ubds_pkg::BAUD_W){1'b0}}, rate_r};
  assign quo       = drsp.quo;

  assign dreq.start = start_r;
  assign dreq.num   = num_r;
  assign dreq.den   = den_r;

  ubds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt  = state_r;
    clk_nxt    = clk_r;
    rate_nxt   = rate_r;
    div_nxt    = div_r;
    gen_nxt    = gen_r;
    err_nxt    = err_r;
    hit_nxt    = hit_r;
    start_nxt  = 1'b0;
    num_nxt    = num_r;
    den_nxt    = den_r;
    ovalid_nxt = ovalid_r;
    odiv_nxt   = odiv_r;
    ogen_nxt   = ogen_r;
    ofound_nxt = ofound_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          clk_nxt  = in_clock_hz;
          rate_nxt = in_baud_request;
          // Clamp the rate on slow reference clocks.
          if (in_clock_hz < ubds_pkg::SLOW_CLK_LIMIT &&
              in_baud_request > ubds_pkg::SLOW_RATE_CAP) begin
            rate_nxt = ubds_pkg::SLOW_RATE_CAP;
          end
          div_nxt   = ubds_pkg::DIV_FIRST;
          hit_nxt   = 1'b0;
          state_nxt = S_GEN_MUL;
        end
      end
      S_GEN_MUL: begin
        num_nxt   = clk_r;
        den_nxt   = rate_prod[ubds_pkg::GEN_W-1:0];
        start_nxt = 1'b1;
        state_nxt = S_GEN_DIV;
      end
      S_GEN_DIV: begin
        if (drsp.done) begin
          gen_nxt = quo;
          if (quo < ubds_pkg::GEN_MIN || quo > ubds_pkg::GEN_MAX) begin
            state_nxt = S_NEXT;
          end else begin
            state_nxt = S_ACH_MUL;
          end
        end
      end
      S_ACH_MUL: begin
        num_nxt   = clk_r;
        den_nxt   = {{(ubds_pkg::GEN_W-17-ubds_pkg::DIV_W){1'b0}}, gen_prod};
        start_nxt = 1'b1;
        state_nxt = S_ACH_DIV;
      end
      S_ACH_DIV: begin
        if (drsp.done) begin
          err_nxt   = (rate_ext > quo) ? rate_ext - quo : quo - rate_ext;
          state_nxt = S_ERR_MUL;
        end
      end
      S_ERR_MUL: begin
        // Product wraps at 32 bits.
        num_nxt   = err_prod[ubds_pkg::GEN_W-1:0];
        den_nxt   = rate_ext;
        start_nxt = 1'b1;
        state_nxt = S_ERR_DIV;
      end
      S_ERR_DIV: begin
        if (drsp.done) begin
          if (quo < ubds_pkg::ERR_LIMIT) begin
            hit_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (div_r == ubds_pkg::DIV_LAST) begin
          div_nxt   = ubds_pkg::DIV_NONE;
          state_nxt = S_DONE;
        end else begin
          div_nxt   = div_r + 1'b1;
          state_nxt = S_GEN_MUL;
        end
      end
      S_DONE: begin
        // Hold until the output slot is free.
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          odiv_nxt   = div_r;
          ogen_nxt   = gen_r;
          ofound_nxt = hit_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      start_r  <= start_nxt;
      ovalid_r <= ovalid_nxt;
    end
    clk_r    <= clk_nxt;
    rate_r   <= rate_nxt;
    div_r    <= div_nxt;
    gen_r    <= gen_nxt;
    err_r    <= err_nxt;
    hit_r    <= hit_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    odiv_r   <= odiv_nxt;
    ogen_r   <= ogen_nxt;
    ofound_r <= ofound_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = ovalid_r;
  assign out_divider   = odiv_r;
  assign out_generator = ogen_r;
  assign out_found     = ofound_r;

endmodule
`default_nettype wire

// ===== src/ubds_div.sv =====
`default_nettype none
module ubds_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ubds_pkg::div_req_t req,
  output ubds_pkg::div_rsp_t     rsp
);

  logic [ubds_pkg::GEN_W-1:0]  rem_r, rem_nxt;
  logic [ubds_pkg::GEN_W-1:0]  den_r, den_nxt;
  logic [ubds_pkg::GEN_W-1:0]  quo_r, quo_nxt;
  logic [ubds_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [ubds_pkg::GEN_W:0]    trial;

  // Restoring division, one quotient bit a cycle; a zero divisor gives all ones.
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[ubds_pkg::GEN_W-1]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = req.num;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[ubds_pkg::GEN_W]) begin
        rem_nxt = trial[ubds_pkg::GEN_W-1:0];
        quo_nxt = {quo_r[ubds_pkg::GEN_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[ubds_pkg::GEN_W-2:0], quo_r[ubds_pkg::GEN_W-1]};
        quo_nxt = {quo_r[ubds_pkg::GEN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

// ===== src/ubds_chk.sv =====
`default_nettype none
`include "uart_baud_divisor_search_defines.svh"
module ubds_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [ubds_pkg::CLK_W-1:0]  in_clock_hz,
  input wire logic [ubds_pkg::BAUD_W-1:0] in_baud_request,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [ubds_pkg::DIV_W-1:0]  out_divider,
  input wire logic [ubds_pkg::GEN_W-1:0]  out_generator,
  input wire logic                         out_found
);

  logic unused_in;
  assign unused_in = in_valid ^ in_ready ^ (^in_clock_hz) ^ (^in_baud_request);

  `UBDS_ASSERT_ALWAYS(a_rst_drop, !rst_n |=> !out_valid)
  `UBDS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_generator))
  `UBDS_ASSERT(a_found_div, out_valid |-> (out_found == (out_divider != ubds_pkg::DIV_NONE)))
  `UBDS_ASSERT(a_found_range, out_valid && out_found |-> out_divider >= ubds_pkg::DIV_FIRST && out_generator >= ubds_pkg::GEN_MIN && out_generator <= ubds_pkg::GEN_MAX)

endmodule

bind uart_baud_divisor_search ubds_chk u_ubds_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_clock_hz     (in_clock_hz),
  .in_baud_request (in_baud_request),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_divider     (out_divider),
  .out_generator   (out_generator),
  .out_found       (out_found)
);
`default_nettype wire

// ===== bench/tb_uart_baud_divisor_search.sv =====
module tb_uart_baud_divisor_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned WATCHDOG_LIMIT = 150000;
  localparam int unsigned END_DRAIN      = 200;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_ITEMS   = 68;

  typedef logic [ubds_pkg::BAUD_W-1:0] baud_t;

  typedef struct packed {
    logic [ubds_pkg::CLK_W-1:0]  clock_hz;
    logic [ubds_pkg::BAUD_W-1:0] baud;
  } baud_request_t;

  typedef struct packed {
    logic [ubds_pkg::DIV_W-1:0] divider;
    logic [ubds_pkg::GEN_W-1:0] generator;
    logic                       found;
  } divisor_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ubds_pkg::CLK_W-1:0]  in_clock_hz = '0;
  logic [ubds_pkg::BAUD_W-1:0] in_baud_request = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ubds_pkg::DIV_W-1:0]  out_divider;
  logic [ubds_pkg::GEN_W-1:0]  out_generator;
  logic                        out_found;

  baud_request_t   pending_requests[$];
  divisor_result_t expected_divisors[$];

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned found_count = 0;
  int unsigned exhausted_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned held_input_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  bit          hold_request = 1'b0;
  bit          in_taken = 1'b0;

  int unsigned std_bauds[12] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                 115200, 230400, 460800, 921600};

  uart_baud_divisor_search u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_clock_hz     (in_clock_hz),
    .in_baud_request (in_baud_request),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_divider     (out_divider),
    .out_generator   (out_generator),
    .out_found       (out_found)
  );

  always #1ns clk = ~clk;

  // Division by zero gives all ones, as a restoring divider does.
  function automatic logic [31:0] quot_or_ones(logic [31:0] num, logic [31:0] den);
    if (den == 32'd0) begin
      return 32'hFFFF_FFFF;
    end
    return num / den;
  endfunction

  function automatic divisor_result_t predict_divisor(
      logic [ubds_pkg::CLK_W-1:0] clock_hz, logic [ubds_pkg::BAUD_W-1:0] baud);
    logic [31:0]     rate;
    logic [31:0]     gen;
    logic [31:0]     achieved;
    logic [31:0]     err;
    logic [31:0]     d;
    logic            hit;
    divisor_result_t r;
    rate = {8'd0, baud};
    if (clock_hz < ubds_pkg::SLOW_CLK_LIMIT && rate > {8'd0, ubds_pkg::SLOW_RATE_CAP}) begin
      rate = {8'd0, ubds_pkg::SLOW_RATE_CAP};
    end
    gen = '0;
    hit = 1'b0;
    d = {24'd0, ubds_pkg::DIV_FIRST};
    while (!hit && d < {24'd0, ubds_pkg::DIV_NONE}) begin
      gen = quot_or_ones(clock_hz, rate * (d + 32'd1));
      if (gen >= ubds_pkg::GEN_MIN && gen <= ubds_pkg::GEN_MAX) begin
        achieved = quot_or_ones(clock_hz, gen * (d + 32'd1));
        err = (rate > achieved) ? rate - achieved : achieved - rate;
        // the scaled error wraps at 32 bits before the compare
        hit = quot_or_ones(err * {25'd0, ubds_pkg::ERR_SCALE}, rate) < ubds_pkg::ERR_LIMIT;
      end
      if (!hit) begin
        d = d + 32'd1;
      end
    end
    r.divider = d[ubds_pkg::DIV_W-1:0];
    r.generator = gen;
    r.found = hit;
    return r;
  endfunction

  task automatic queue_request(logic [ubds_pkg::CLK_W-1:0] clock_hz,
                               logic [ubds_pkg::BAUD_W-1:0] baud);
    baud_request_t req;
    req.clock_hz = clock_hz;
    req.baud = baud;
    pending_requests.push_back(req);
    items_queued++;
  endtask

  // Sender: bursts of transactions separated by random gaps.
  always @(negedge clk) begin : driver
    logic          next_valid;
    baud_request_t next_req;
    next_valid = in_valid;
    if (in_taken) begin
      next_valid = 1'b0;
      in_taken = 1'b0;
    end
    if (rst_n && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        in_clock_hz <= next_req.clock_hz;
        in_baud_request <= next_req.baud;
        next_valid = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 6);
        end
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Receiver: short random stalls, calm stretches, and the long hold-off on request.
  always @(negedge clk) begin : receiver
    logic next_ready;
    next_ready = 1'b1;
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (!rst_n) begin
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
    end else if (stall_left > 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 15);
      next_ready = 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      calm_left = $urandom_range(100, 2000);
    end
    out_ready <= next_ready;
  end

  always @(posedge clk) begin : monitor
    divisor_result_t want;
    divisor_result_t got;
    if (rst_n) begin
      idle_cycles++;
      // check the result before recording this edge's request
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        results_checked++;
        got = {out_divider, out_generator, out_found};
        if (expected_divisors.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result with no request outstanding: %s %0d %s %0d %s %0b",
                     $realtime, "divider", out_divider, "generator", out_generator,
                     "found", out_found);
          end
        end else begin
          want = expected_divisors.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected divider %0d generator %0d found %0b,",
                       $realtime, want.divider, want.generator, want.found);
              $display("    got divider %0d generator %0d found %0b",
                       got.divider, got.generator, got.found);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        want = predict_divisor(in_clock_hz, in_baud_request);
        expected_divisors.push_back(want);
        if (want.found) begin
          found_count++;
        end else begin
          exhausted_count++;
        end
        items_accepted++;
        in_taken = 1'b1;
      end
      if (hold_left > 0 && in_valid && !in_ready) begin
        held_input_cycles++;
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("** uart_baud_divisor_search: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    logic [ubds_pkg::CLK_W-1:0]  clock_hz;
    logic [ubds_pkg::BAUD_W-1:0] baud;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero rate: every division gives all ones
    queue_request(32'd100_000_000, 24'd0);
    // zero clock, clamped rate, generator always zero
    queue_request(32'd0, 24'd115200);
    queue_request(32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_request(32'hFFFF_FFFF, 24'd1);
    // slow clock clamp edges
    queue_request(32'd999_999, 24'd4800);
    queue_request(32'd999_999, 24'd4801);
    queue_request(32'd999_999, 24'd115200);
    queue_request(32'd1_000_000, 24'd115200);
    queue_request(32'd1_000_000, 24'd4800);
    // generator range edges
    queue_request(32'd10_000_000, 24'd1_000_000);
    queue_request(32'd9_999_999, 24'd1_000_000);
    queue_request(32'd327_675, 24'd1);
    queue_request(32'd327_680, 24'd1);
    // ordinary cases, some needing a later divider
    queue_request(32'd100_000_000, 24'd115200);
    queue_request(32'd50_000_000, 24'd9600);
    queue_request(32'd33_333_333, 24'd921600);
    queue_request(32'd1_843_200, 24'd115200);
    queue_request(32'd12_000_000, 24'd460800);
    queue_request(32'd0, 24'd0);
    queue_request(32'h8000_0000, 24'h80_0000);
    wait (items_accepted == items_queued && results_checked == items_accepted);

    // hold the output back while quick requests keep coming
    @(posedge clk);
    hold_request = 1'b1;
    repeat (12) begin
      queue_request($urandom_range(50_000_000, 100_000_000), 24'd115200);
    end
    wait (items_accepted == items_queued && results_checked == items_accepted);

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        clock_hz = $urandom_range(1_000_000, 200_000_000);
        baud = baud_t'(std_bauds[$urandom_range(0, 11)]);
      end else if (pick < 65) begin
        clock_hz = $urandom_range(1_000_000, 200_000_000);
        baud = baud_t'($urandom_range(300, 1_000_000));
      end else if (pick < 78) begin
        clock_hz = $urandom_range(0, 999_999);
        baud = baud_t'($urandom_range(1, 16_000_000));
      end else if (pick < 93) begin
        clock_hz = $urandom;
        baud = baud_t'($urandom_range(1, 24'hFF_FFFF));
      end else begin
        clock_hz = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
        baud = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'hFF_FFFF;
      end
      queue_request(clock_hz, baud);
    end

    wait (items_accepted == items_queued && results_checked == items_accepted);
    repeat (END_DRAIN) @(posedge clk);

    $display("Covered %0d requests: %0d settled on a divider, %0d ran the search out.",
             items_accepted, found_count, exhausted_count);
    $display("Output held off for %0d cycles with the input backed up for %0d of them.",
             HOLD_CYCLES, held_input_cycles);
    if (mismatches == 0 && expected_divisors.size() == 0) begin
      $display("** uart_baud_divisor_search: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_divisors.size());
      $display("** uart_baud_divisor_search: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ubds_pkg.sv
src/ubds_div.sv
src/uart_baud_divisor_search.sv
src/ubds_chk.sv
bench/tb_uart_baud_divisor_search.sv
